### src/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk, off while rst is high.
`define FRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check sampled on clk, also during reset.
`define FRE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/fre_pkg.sv
// Types, character codes and residue lookup for the FASTA residue stream encoder.
// No dependencies.
package fre_pkg;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_HEAD = 2'd1,
    PH_SEQ  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RES = 2'd0,
    KIND_HDR = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam int REC_LEN_W = 20;
  localparam int TOTAL_W   = 32;

  typedef struct packed {
    logic       hit;
    logic [4:0] index;
  } res_lookup_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            symbol;
    logic [REC_LEN_W-1:0]  record_length;
    logic [TOTAL_W-1:0]    total_symbols;
    logic                  record_dropped;
    logic                  is_last;
  } result_t;

  function automatic res_lookup_t nuc_lookup(input logic [7:0] c);
    res_lookup_t r;
    r.hit = 1'b1;
    case (c)
      "A": r.index = 5'd0;
      "C": r.index = 5'd1;
      "G": r.index = 5'd2;
      "T": r.index = 5'd3;
      "U": r.index = 5'd4;
      "R": r.index = 5'd5;
      "Y": r.index = 5'd6;
      "K": r.index = 5'd7;
      "M": r.index = 5'd8;
      "S": r.index = 5'd9;
      "W": r.index = 5'd10;
      "B": r.index = 5'd11;
      "D": r.index = 5'd12;
      "H": r.index = 5'd13;
      "V": r.index = 5'd14;
      "N": r.index = 5'd15;
      "X": r.index = 5'd16;
      default: begin
        r.hit   = 1'b0;
        r.index = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Substitutions U->C, O->K, * -> X are folded into the table.
  function automatic res_lookup_t amino_lookup(input logic [7:0] c);
    res_lookup_t r;
    r.hit = 1'b1;
    case (c)
      "A": r.index = 5'd0;
      "B": r.index = 5'd1;
      "C", "U": r.index = 5'd2;
      "D": r.index = 5'd3;
      "E": r.index = 5'd4;
      "F": r.index = 5'd5;
      "G": r.index = 5'd6;
      "H": r.index = 5'd7;
      "I": r.index = 5'd8;
      "K", "O": r.index = 5'd9;
      "L": r.index = 5'd10;
      "M": r.index = 5'd11;
      "N": r.index = 5'd12;
      "P": r.index = 5'd13;
      "Q": r.index = 5'd14;
      "R": r.index = 5'd15;
      "S": r.index = 5'd16;
      "T": r.index = 5'd17;
      "V": r.index = 5'd18;
      "W": r.index = 5'd19;
      "Y": r.index = 5'd20;
      "Z": r.index = 5'd21;
      "X", CH_STAR: r.index = 5'd22;
      default: begin
        r.hit   = 1'b0;
        r.index = 5'd0;
      end
    endcase
    return r;
  endfunction

endpackage

### src/fre_residue_map.sv
// Residue mapper: upper-cases a sequence byte and looks up its alphabet index.
// Depends on fre_pkg.
module fre_residue_map import fre_pkg::*; (
  input  logic [7:0]  in_byte,
  input  logic        dna_mode,
  output res_lookup_t lookup
);

  logic [7:0] upper;

  always_comb begin
    if (in_byte >= CH_LA && in_byte <= CH_LZ) begin
      upper = in_byte - CASE_OFS;
    end else begin
      upper = in_byte;
    end
  end

  always_comb begin
    if (dna_mode) begin
      lookup = nuc_lookup(upper);
    end else begin
      lookup = amino_lookup(upper);
    end
  end

endmodule

### src/fre_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while take is high.
// Depends on fre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fre_fifo import fre_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t din0,
  input  result_t din1,
  input  logic    take,
  output logic    room,
  output logic    valid,
  output result_t dout
);

  result_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;
  logic [FIFO_CNT_W-1:0]  push_n;
  logic                   pop;

  assign push_n = FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1);
  assign valid  = (count != '0);
  assign pop    = valid && take;
  assign room   = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign dout   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_n);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count + push_n - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push1) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= din1;
    end
  end

  `FRE_ASSERT(a_count_bound, count <= FIFO_CNT_W'(FIFO_DEPTH), "fifo count above depth")
  `FRE_ASSERT(a_push_order, push1 |-> push0, "second result pushed without first")
  `FRE_ASSERT(a_pop_only, (pop && !push0) |=> count == $past(count) - FIFO_CNT_W'(1), "fifo pop lost")

endmodule

### src/fasta_residue_stream_encoder.sv
// FASTA residue stream encoder: one byte per transaction in, up to two results out.
// Each result is written into the result queue with its byte's transaction and is presented from the queue head.
// One byte per cycle while the result queue has room; a byte with two results presents them one after the other,
// set by the single-result output port draining a four-entry result queue.
// Reset (rst, synchronous): parser returns to skip-first-byte, totals cleared,
// dna_mode 0. Depends on fre_pkg, fre_residue_map, fre_fifo, assert_macros.svh.
`include "assert_macros.svh"

module fasta_residue_stream_encoder import fre_pkg::*; #(
  parameter int LENGTH_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  symbol,
  output logic [19:0] record_length,
  output logic [31:0] total_symbols,
  output logic        record_dropped,
  output logic        is_last
);

  logic                    dna_mode;
  phase_t                  phase, phase_next;
  logic                    header_started, header_started_next;
  logic                    header_truncated, header_truncated_next;
  logic                    sequence_started, sequence_started_next;
  logic [LENGTH_BITS-1:0]  length_count, length_count_next;
  logic [TOTAL_W-1:0]      symbol_total, symbol_total_next;

  logic        accept;
  res_lookup_t lookup;

  // main result of the byte (header char, residue, or record end on '>')
  logic        main_vld;
  kind_t       main_kind;
  logic [7:0]  main_sym;
  logic        main_len;
  // record end forced by end of file
  logic        eof_vld;
  logic        eof_dropped;

  logic        push0, push1;
  result_t     res0, res1, res_main, res_eof, head;
  logic        room;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_ready  = room;

  fre_residue_map u_map (
    .in_byte  (in_byte),
    .dna_mode (dna_mode),
    .lookup   (lookup)
  );

  // next state
  always_comb begin
    phase_next            = phase;
    header_started_next   = header_started;
    header_truncated_next = header_truncated;
    sequence_started_next = sequence_started;
    length_count_next     = length_count;
    symbol_total_next     = symbol_total;
    if (phase == PH_SKIP) begin
      phase_next            = PH_HEAD;
      header_started_next   = 1'b0;
      header_truncated_next = 1'b0;
    end else if (in_byte == CH_NUL) begin
      phase_next = phase;
    end else if (phase == PH_HEAD) begin
      if (in_byte == CH_LF) begin
        if (header_started) begin
          phase_next            = PH_SEQ;
          sequence_started_next = 1'b0;
          length_count_next     = '0;
        end
      end else begin
        header_started_next = 1'b1;
        if (in_byte == CH_CR) begin
          header_truncated_next = 1'b1;
        end
      end
    end else if (in_byte == CH_GT) begin
      if (sequence_started) begin
        phase_next            = PH_HEAD;
        header_started_next   = 1'b0;
        header_truncated_next = 1'b0;
        sequence_started_next = 1'b0;
        length_count_next     = '0;
      end
    end else begin
      sequence_started_next = 1'b1;
      if (lookup.hit) begin
        if (length_count != '1) begin
          length_count_next = length_count + LENGTH_BITS'(1);
        end
        if (symbol_total != '1) begin
          symbol_total_next = symbol_total + TOTAL_W'(1);
        end
      end
    end
    if (end_of_file) begin
      phase_next            = PH_SKIP;
      header_started_next   = 1'b0;
      header_truncated_next = 1'b0;
      sequence_started_next = 1'b0;
      length_count_next     = '0;
    end
  end

  // results
  always_comb begin
    main_vld  = 1'b0;
    main_kind = KIND_RES;
    main_sym  = 8'd0;
    main_len  = 1'b0;
    if (phase == PH_SKIP || in_byte == CH_NUL) begin
      main_vld = 1'b0;
    end else if (phase == PH_HEAD) begin
      if (in_byte != CH_LF && in_byte != CH_CR && !header_truncated) begin
        main_vld  = 1'b1;
        main_kind = KIND_HDR;
        main_sym  = in_byte;
      end
    end else if (in_byte == CH_GT) begin
      if (sequence_started) begin
        main_vld  = 1'b1;
        main_kind = KIND_END;
        main_len  = 1'b1;
      end
    end else if (lookup.hit) begin
      main_vld = 1'b1;
      main_sym = {3'd0, lookup.index};
    end
  end

  // End-of-file close looks at the state the byte itself leaves behind.
  always_comb begin
    eof_vld     = 1'b0;
    eof_dropped = 1'b0;
    if (end_of_file) begin
      if (phase == PH_SKIP) begin
        eof_vld = 1'b0;
      end else if (main_vld && main_kind == KIND_END) begin
        eof_vld = 1'b0;
      end else if (phase == PH_HEAD) begin
        eof_vld     = header_started || (in_byte != CH_NUL && in_byte != CH_LF);
        eof_dropped = 1'b1;
        if (in_byte == CH_LF && header_started) begin
          eof_vld = 1'b1;
        end
      end else begin
        eof_vld     = 1'b1;
        eof_dropped = !(sequence_started || (in_byte != CH_NUL && in_byte != CH_GT));
      end
    end
  end

  always_comb begin
    res_main.kind           = main_kind;
    res_main.symbol         = main_sym;
    res_main.record_length  = main_len ? REC_LEN_W'(length_count) : '0;
    res_main.total_symbols  = symbol_total_next;
    res_main.record_dropped = 1'b0;
    res_main.is_last        = !eof_vld;

    res_eof.kind            = KIND_END;
    res_eof.symbol          = 8'd0;
    res_eof.record_length   = eof_dropped ? '0 :
                              REC_LEN_W'(phase == PH_SEQ && in_byte != CH_GT ?
                                         (in_byte == CH_NUL ? length_count :
                                          (lookup.hit && length_count != '1 ?
                                           length_count + LENGTH_BITS'(1) :
                                           length_count)) :
                                         length_count);
    res_eof.total_symbols   = symbol_total_next;
    res_eof.record_dropped  = eof_dropped;
    res_eof.is_last         = 1'b1;

    push0 = accept && (main_vld || eof_vld);
    push1 = accept && main_vld && eof_vld;
    res0  = main_vld ? res_main : res_eof;
    res1  = res_eof;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dna_mode         <= 1'b0;
      phase            <= PH_SKIP;
      header_started   <= 1'b0;
      header_truncated <= 1'b0;
      sequence_started <= 1'b0;
      length_count     <= '0;
      symbol_total     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dna_mode <= cfg_data;
      end
      if (accept) begin
        phase            <= phase_next;
        header_started   <= header_started_next;
        header_truncated <= header_truncated_next;
        sequence_started <= sequence_started_next;
        length_count     <= length_count_next;
        symbol_total     <= symbol_total_next;
      end
    end
  end

  fre_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .push1 (push1),
    .din0  (res0),
    .din1  (res1),
    .take  (out_ready),
    .room  (room),
    .valid (out_valid),
    .dout  (head)
  );

  assign kind           = head.kind;
  assign symbol         = head.symbol;
  assign record_length  = head.record_length;
  assign total_symbols  = head.total_symbols;
  assign record_dropped = head.record_dropped;
  assign is_last        = head.is_last;

  `FRE_ASSERT(a_total_mono, 1'b1 |=> symbol_total >= $past(symbol_total), "symbol total went down")
  `FRE_ASSERT(a_skip_silent, (accept && phase == PH_SKIP) |-> !push0, "skipped byte made a result")
  `FRE_ASSERT(a_end_fields, (out_valid && kind != KIND_END) |-> (record_length == '0 && !record_dropped), "record fields on non-end result")
  `FRE_ASSERT(a_eof_restart, (accept && end_of_file) |=> phase == PH_SKIP, "no restart after end of file")

endmodule

### dv/testbench.sv
// Self-checking testbench for fasta_residue_stream_encoder: directed FASTA fragments,
// then random files under varied idling and a long output hold-off.
// Depends on fre_pkg and the encoder RTL; carries its own parser model.
module testbench import fre_pkg::*; ();

  localparam int LEN_BITS     = 20;
  localparam int QUIET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam string NUC_ALPHABET   = "ACGTURYKMSWBDHVNX";
  localparam string AMINO_ALPHABET = "ABCDEFGHIKLMNPQRSTVWYZX";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  symbol;
  logic [19:0] record_length;
  logic [31:0] total_symbols;
  logic        record_dropped;
  logic        is_last;

  // parser model state
  phase_t      parse_phase = PH_SKIP;
  logic        hdr_open = 1'b0;
  logic        hdr_cut = 1'b0;
  logic        seq_open = 1'b0;
  logic [19:0] rec_len = '0;
  logic [31:0] residue_total = '0;
  logic        dna_sel = 1'b0;

  result_t     predicted_results[$];
  result_t     want;
  logic [7:0]  file_buf[$];
  logic        file_is_noise;
  string       residue_pool = "ACGTURYKMSWBDHVNXEFILPQZO*";

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int records_closed = 0;
  int records_dropped = 0;

  always #1 clk = ~clk;

  fasta_residue_stream_encoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_file   (end_of_file),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .symbol        (symbol),
    .record_length (record_length),
    .total_symbols (total_symbols),
    .record_dropped(record_dropped),
    .is_last       (is_last)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  function automatic int residue_index(input logic [7:0] c);
    string alpha;
    alpha = dna_sel ? NUC_ALPHABET : AMINO_ALPHABET;
    for (int i = 0; i < alpha.len(); i++)
      if (alpha[i] == c) return i;
    return -1;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [7:0] sym,
                                          input logic [19:0] len, input logic drop);
    result_t r;
    r.kind           = k;
    r.symbol         = sym;
    r.record_length  = len;
    r.total_symbols  = residue_total;
    r.record_dropped = drop;
    r.is_last        = 1'b0;
    return r;
  endfunction

  // Advances the parser model by one byte and queues the results it causes.
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    result_t    outs[2];
    result_t    r;
    int         n;
    int         idx;
    logic [7:0] c;
    n = 0;
    if (parse_phase == PH_SKIP) begin
      parse_phase = PH_HEAD;
      hdr_open = 1'b0;
      hdr_cut = 1'b0;
    end else if (b == CH_NUL) begin
    end else if (parse_phase == PH_HEAD) begin
      if (b == CH_LF) begin
        if (hdr_open) begin
          parse_phase = PH_SEQ;
          seq_open = 1'b0;
          rec_len = '0;
        end
      end else begin
        hdr_open = 1'b1;
        if (b == CH_CR) begin
          hdr_cut = 1'b1;
        end else if (!hdr_cut) begin
          outs[n] = make_result(KIND_HDR, b, '0, 1'b0);
          n = n + 1;
        end
      end
    end else begin
      if (b == CH_GT) begin
        if (seq_open) begin
          outs[n] = make_result(KIND_END, '0, rec_len, 1'b0);
          n = n + 1;
          parse_phase = PH_HEAD;
          hdr_open = 1'b0;
          hdr_cut = 1'b0;
          seq_open = 1'b0;
          rec_len = '0;
        end
      end else begin
        seq_open = 1'b1;
        c = b;
        if (c >= CH_LA && c <= CH_LZ) c = c - CASE_OFS;
        if (!dna_sel) begin
          if (c == "U") c = "C";
          else if (c == "O") c = "K";
          else if (c == CH_STAR) c = "X";
        end
        idx = residue_index(c);
        if (idx >= 0) begin
          if (rec_len != LEN_MAX) rec_len = rec_len + 1'b1;
          if (residue_total != '1) residue_total = residue_total + 1'b1;
          outs[n] = make_result(KIND_RES, 8'(idx), '0, 1'b0);
          n = n + 1;
        end
      end
    end
    if (eof) begin
      if (parse_phase == PH_HEAD && hdr_open) begin
        outs[n] = make_result(KIND_END, '0, '0, 1'b1);
        n = n + 1;
      end else if (parse_phase == PH_SEQ) begin
        outs[n] = seq_open ? make_result(KIND_END, '0, rec_len, 1'b0)
                           : make_result(KIND_END, '0, '0, 1'b1);
        n = n + 1;
      end
      parse_phase = PH_SKIP;
      hdr_open = 1'b0;
      hdr_cut = 1'b0;
      seq_open = 1'b0;
      rec_len = '0;
    end
    for (int i = 0; i < n; i++) begin
      r = outs[i];
      r.is_last = (i == n - 1);
      predicted_results = {predicted_results, r};
    end
  endtask

  // Entered at a rising edge; leaves at the edge of the transaction with valid still high.
  task automatic send_fasta_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    parse_byte(b, eof);
  endtask

  task automatic send_text(input string s, input logic eof_on_last);
    for (int i = 0; i < s.len(); i++)
      send_fasta_byte(s[i], eof_on_last && (i == s.len() - 1));
  endtask

  task automatic write_mode(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dna_sel = value;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] residue_byte();
    logic [7:0] c;
    if ($urandom_range(11) == 0) return 8'($urandom_range(255));
    c = residue_pool[$urandom_range(residue_pool.len() - 1)];
    if (c != CH_STAR && $urandom_range(2) == 0) c = c + CASE_OFS;
    return c;
  endfunction

  // Mostly well-formed files with random content; some noise, some cut short.
  task automatic build_file();
    int         n_rec;
    int         n_lines;
    int         cut;
    logic [7:0] c;
    file_buf.delete();
    file_is_noise = ($urandom_range(9) == 0);
    if (file_is_noise) begin
      repeat ($urandom_range(1, 24)) file_buf = {file_buf, 8'($urandom_range(255))};
      return;
    end
    file_buf = {file_buf, (($urandom_range(19) == 0) ? 8'($urandom_range(255)) : CH_GT)};
    n_rec = $urandom_range(1, 3);
    for (int r = 0; r < n_rec; r++) begin
      if (r > 0) file_buf = {file_buf, CH_GT};
      if ($urandom_range(4) == 0) file_buf = {file_buf, CH_LF};
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(19))
          0:       c = CH_CR;
          1:       c = CH_NUL;
          2:       c = 8'($urandom_range(255));
          default: c = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        file_buf = {file_buf, c};
      end
      file_buf = {file_buf, CH_LF};
      n_lines = $urandom_range(0, 3);
      for (int l = 0; l < n_lines; l++) begin
        repeat ($urandom_range(0, 12)) file_buf = {file_buf, residue_byte()};
        if ($urandom_range(7) == 0) file_buf = {file_buf, CH_CR};
        file_buf = {file_buf, CH_LF};
      end
    end
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(file_buf.size() - 1);
      repeat (cut) void'(file_buf.pop_back());
    end
  endtask

  task automatic send_file();
    logic eof;
    for (int i = 0; i < file_buf.size(); i++) begin
      eof = (i == file_buf.size() - 1) || (file_is_noise && $urandom_range(9) == 0);
      send_fasta_byte(file_buf[i], eof);
    end
  endtask

  task automatic send_random_files(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      build_file();
      send_file();
    end
  endtask

  task automatic test_directed_protein();
    write_mode(1'b0);
    send_text(">\nh", 1'b0);
    send_fasta_byte(CH_CR, 1'b0);
    send_text("x\n>uo*aZJ", 1'b0);
    send_fasta_byte(8'hFF, 1'b0);
    send_text(">p\nc", 1'b0);
    send_fasta_byte(CH_NUL, 1'b1);
    send_text(">", 1'b1);
    send_text(">q", 1'b1);
    send_text(">k\n", 1'b1);
  endtask

  task automatic test_directed_nucleotide();
    wait_quiet();
    write_mode(1'b1);
    send_text(">n\nu*xg", 1'b1);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall, input logic mode);
    wait_quiet();
    write_mode(mode);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    send_random_files(n_items);
  endtask

  task automatic test_output_backpressure();
    wait_quiet();
    write_mode(1'b1);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    send_random_files(80);
  endtask

  // receiver: random stalls plus a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = predicted_results.pop_front();
        check_field("kind", 32'(kind), 32'(want.kind));
        check_field("symbol", 32'(symbol), 32'(want.symbol));
        check_field("record_length", 32'(record_length), 32'(want.record_length));
        check_field("total_symbols", total_symbols, want.total_symbols);
        check_field("record_dropped", 32'(record_dropped), 32'(want.record_dropped));
        check_field("is_last", 32'(is_last), 32'(want.is_last));
        results_checked++;
        if (want.kind == KIND_END) begin
          records_closed++;
          if (want.record_dropped) records_dropped++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_protein();
    test_directed_nucleotide();
    test_random_traffic(140, 0, 0, 1'b1);
    test_random_traffic(120, 82, 0, 1'b0);
    test_random_traffic(120, 0, 82, 1'b1);
    test_random_traffic(140, 6, 6, 1'b0);
    test_output_backpressure();
    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && predicted_results.size() != 0; i++) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                predicted_results.size()));
    $display("Sent %0d bytes in both alphabet modes under four idling mixes and a hold-off;",
             items_sent);
    $display("checked %0d results, %0d record ends (%0d dropped), %0d mismatches.",
             results_checked, records_closed, records_dropped, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: run did not finish");
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/fre_pkg.sv
src/fre_residue_map.sv
src/fre_fifo.sv
src/fasta_residue_stream_encoder.sv
dv/testbench.sv
